// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check out of reset only.
`define FQS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define FQS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/fqs_pkg.sv
// ----------------------------------------------------------------------------
// FASTQ statistics package
// Sizes, codes, command format and helpers shared by the block.
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int MAX_POS     = 128;
  localparam int HIST_BINS   = 64;
  localparam int NUM_BASES   = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam int OP_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 7;
  localparam int OFFSET_W = 7;
  localparam int COUNT_W  = 32;

  localparam int HIST_AW  = $clog2(HIST_BINS);
  localparam int COL_AW   = $clog2(MAX_POS);
  localparam int COLUMN_W = $clog2(MAX_POS + 1);
  localparam int BASE_W   = 3;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(33);

  localparam logic [BYTE_W-1:0] CHAR_NL = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_T  = 8'h54;
  localparam logic [BYTE_W-1:0] CHAR_G  = 8'h47;
  localparam logic [BYTE_W-1:0] CHAR_C  = 8'h43;

  localparam logic [BASE_W-1:0] BASE_A = 3'd0;
  localparam logic [BASE_W-1:0] BASE_T = 3'd1;
  localparam logic [BASE_W-1:0] BASE_G = 3'd2;
  localparam logic [BASE_W-1:0] BASE_C = 3'd3;
  localparam logic [BASE_W-1:0] BASE_N = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_STREAM  = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_RD_HIST = 3'd2,
    OP_RD_COL  = 3'd3,
    OP_RD_BASE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CMD_SEQ     = 3'd0,
    CMD_QUAL    = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_RD_HIST = 3'd3,
    CMD_RD_COL  = 3'd4,
    CMD_RD_BASE = 3'd5
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [BASE_W-1:0]   base;
    logic                is_gc;
    logic                col_ok;
    logic [COL_AW-1:0]   col_addr;
    logic [HIST_AW-1:0]  hist_addr;
    logic                zero;
  } cmd_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v,
                                                 input logic en);
    logic [COUNT_W-1:0] r;
    r = v;
    if (en && (v != COUNT_MAX)) begin
      r = v + COUNT_W'(1);
    end
    return r;
  endfunction

endpackage

// File: hdl/fqs_if.sv
// ----------------------------------------------------------------------------
// FASTQ statistics channels
// Valid/ready channels for input items, results and the offset register.
// ----------------------------------------------------------------------------
interface fqs_in_if import fqs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [BYTE_W-1:0]   byte_value;
  logic [INDEX_W-1:0]  index;

  modport source (output valid, op, byte_value, index, input ready);
  modport sink   (input valid, op, byte_value, index, output ready);
endinterface

interface fqs_out_if import fqs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  count_main;
  logic [COUNT_W-1:0]  count_total;

  modport source (output valid, count_main, count_total, input ready);
  modport sink   (input valid, count_main, count_total, output ready);
endinterface

interface fqs_cfg_if import fqs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/fqs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// FASTQ statistics command queue
// Short queue of decoded commands between the front and back parts.
// ----------------------------------------------------------------------------
module fqs_cmd_fifo import fqs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  input  logic pop_i,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: hdl/fqs_front.sv
// ----------------------------------------------------------------------------
// FASTQ statistics front end
// Accepts items, tracks line phase and column, decodes counter commands.
// ----------------------------------------------------------------------------
module fqs_front import fqs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  fqs_in_if.sink        in_i,
  fqs_cfg_if.sink       cfg_i,
  input  logic          push_ready_i,
  output logic          push_o,
  output cmd_t          push_cmd_o
);

  localparam logic [1:0] PHASE_HEADER = 2'd0;
  localparam logic [1:0] PHASE_SEQ    = 2'd1;
  localparam logic [1:0] PHASE_QUAL   = 2'd3;

  logic [1:0]          phase_q, phase_d;
  logic [COLUMN_W-1:0] column_q, column_d;
  logic [OFFSET_W-1:0] offset_q;
  logic                in_acc;
  logic [BYTE_W-1:0]   qual_diff;

  assign in_i.ready  = push_ready_i;
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign qual_diff   = in_i.byte_value - BYTE_W'(offset_q);

  always_comb begin
    phase_d    = phase_q;
    column_d   = column_q;
    push_o     = 1'b0;
    push_cmd_o = '0;
    if (in_acc) begin
      case (in_i.op)
        OP_STREAM: begin
          if (in_i.byte_value == CHAR_NL) begin
            phase_d  = phase_q + 2'd1;
            column_d = '0;
          end else if (phase_q == PHASE_SEQ) begin
            push_o           = 1'b1;
            push_cmd_o.kind  = CMD_SEQ;
            push_cmd_o.is_gc = (in_i.byte_value == CHAR_G) || (in_i.byte_value == CHAR_C);
            case (in_i.byte_value)
              CHAR_A:  push_cmd_o.base = BASE_A;
              CHAR_T:  push_cmd_o.base = BASE_T;
              CHAR_G:  push_cmd_o.base = BASE_G;
              CHAR_C:  push_cmd_o.base = BASE_C;
              default: push_cmd_o.base = BASE_N;
            endcase
            if (column_q < COLUMN_W'(MAX_POS)) begin
              push_cmd_o.col_ok   = 1'b1;
              push_cmd_o.col_addr = column_q[COL_AW-1:0];
              column_d            = column_q + COLUMN_W'(1);
            end
          end else if (phase_q == PHASE_QUAL) begin
            if (in_i.byte_value >= BYTE_W'(offset_q)) begin
              push_o          = 1'b1;
              push_cmd_o.kind = CMD_QUAL;
              if ({1'b0, qual_diff} >= 9'(HIST_BINS)) begin
                push_cmd_o.hist_addr = HIST_AW'(HIST_BINS - 1);
              end else begin
                push_cmd_o.hist_addr = HIST_AW'(qual_diff);
              end
            end
          end
        end
        OP_CLEAR: begin
          push_o          = 1'b1;
          push_cmd_o.kind = CMD_CLEAR;
          phase_d         = PHASE_HEADER;
          column_d        = '0;
        end
        OP_RD_HIST: begin
          push_o               = 1'b1;
          push_cmd_o.kind      = CMD_RD_HIST;
          push_cmd_o.hist_addr = HIST_AW'(in_i.index);
          push_cmd_o.zero      = (32'(in_i.index) >= 32'(HIST_BINS));
        end
        OP_RD_COL: begin
          push_o              = 1'b1;
          push_cmd_o.kind     = CMD_RD_COL;
          push_cmd_o.col_addr = COL_AW'(in_i.index);
          push_cmd_o.zero     = (32'(in_i.index) >= 32'(MAX_POS));
        end
        OP_RD_BASE: begin
          push_o          = 1'b1;
          push_cmd_o.kind = CMD_RD_BASE;
          push_cmd_o.base = in_i.index[BASE_W-1:0];
          push_cmd_o.zero = (32'(in_i.index) >= 32'(NUM_BASES));
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PHASE_HEADER;
      column_q <= '0;
      offset_q <= OFFSET_RESET;
    end else begin
      phase_q  <= phase_d;
      column_q <= column_d;
      if (cfg_i.valid && cfg_i.ready) begin
        offset_q <= cfg_i.data;
      end
    end
  end

endmodule

// File: hdl/fqs_back.sv
// ----------------------------------------------------------------------------
// FASTQ statistics back end
// Counter stores with read-modify-write pipeline and result register.
// ----------------------------------------------------------------------------
module fqs_back import fqs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  fqs_out_if.source  out_o
);

  localparam int COL_DW = 2 * COUNT_W;

  logic [COUNT_W-1:0] hist_mem [HIST_BINS];
  logic [COL_DW-1:0]  col_mem  [MAX_POS];

  logic [HIST_BINS-1:0] hist_vld_q;
  logic [MAX_POS-1:0]   col_vld_q;
  logic [NUM_BASES-1:0][COUNT_W-1:0] base_q;

  logic               b_valid_q;
  cmd_t               b_cmd_q;
  logic [COUNT_W-1:0] hist_rd_q;
  logic [COL_DW-1:0]  col_rd_q;

  logic               hfwd_v_q;
  logic [HIST_AW-1:0] hfwd_addr_q;
  logic [COUNT_W-1:0] hfwd_data_q;
  logic               cfwd_v_q;
  logic [COL_AW-1:0]  cfwd_addr_q;
  logic [COL_DW-1:0]  cfwd_data_q;

  logic               out_valid_q;
  logic [COUNT_W-1:0] out_main_q, out_main_d;
  logic [COUNT_W-1:0] out_total_q, out_total_d;

  logic               b_is_rd, b_adv, issue;
  logic               hist_we, col_we, base_we, do_clear;
  logic [COUNT_W-1:0] hist_cur, hist_new, base_cur;
  logic [COL_DW-1:0]  col_cur, col_new;

  assign b_is_rd = (b_cmd_q.kind == CMD_RD_HIST) || (b_cmd_q.kind == CMD_RD_COL) ||
                   (b_cmd_q.kind == CMD_RD_BASE);
  assign b_adv   = b_valid_q && (!b_is_rd || !out_valid_q || out_o.ready);
  assign issue   = cmd_valid_i && (!b_valid_q || b_adv);
  assign cmd_pop_o = issue;

  assign hist_we  = b_adv && (b_cmd_q.kind == CMD_QUAL);
  assign col_we   = b_adv && (b_cmd_q.kind == CMD_SEQ) && b_cmd_q.col_ok;
  assign base_we  = b_adv && (b_cmd_q.kind == CMD_SEQ);
  assign do_clear = b_adv && (b_cmd_q.kind == CMD_CLEAR);

  always_comb begin
    if (hfwd_v_q && (hfwd_addr_q == b_cmd_q.hist_addr)) begin
      hist_cur = hfwd_data_q;
    end else if (hist_vld_q[b_cmd_q.hist_addr]) begin
      hist_cur = hist_rd_q;
    end else begin
      hist_cur = '0;
    end
    if (cfwd_v_q && (cfwd_addr_q == b_cmd_q.col_addr)) begin
      col_cur = cfwd_data_q;
    end else if (col_vld_q[b_cmd_q.col_addr]) begin
      col_cur = col_rd_q;
    end else begin
      col_cur = '0;
    end
    base_cur = '0;
    for (int i = 0; i < NUM_BASES; i++) begin
      if (b_cmd_q.base == BASE_W'(i)) begin
        base_cur = base_q[i];
      end
    end
    hist_new = sat_inc(hist_cur, 1'b1);
    col_new  = {sat_inc(col_cur[COL_DW-1:COUNT_W], b_cmd_q.is_gc),
                sat_inc(col_cur[COUNT_W-1:0], 1'b1)};
  end

  always_comb begin
    out_main_d  = '0;
    out_total_d = '0;
    if (!b_cmd_q.zero) begin
      case (b_cmd_q.kind)
        CMD_RD_HIST: out_main_d = hist_cur;
        CMD_RD_COL: begin
          out_main_d  = col_cur[COL_DW-1:COUNT_W];
          out_total_d = col_cur[COUNT_W-1:0];
        end
        CMD_RD_BASE: out_main_d = base_cur;
        default:     out_main_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      hist_vld_q  <= '0;
      col_vld_q   <= '0;
      base_q      <= '0;
      hfwd_v_q    <= 1'b0;
      cfwd_v_q    <= 1'b0;
    end else begin
      if (issue) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv && b_is_rd) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (do_clear) begin
        hist_vld_q <= '0;
        col_vld_q  <= '0;
        base_q     <= '0;
        hfwd_v_q   <= 1'b0;
        cfwd_v_q   <= 1'b0;
      end else begin
        if (hist_we) begin
          hist_vld_q[b_cmd_q.hist_addr] <= 1'b1;
          hfwd_v_q                      <= 1'b1;
        end
        if (col_we) begin
          col_vld_q[b_cmd_q.col_addr] <= 1'b1;
          cfwd_v_q                    <= 1'b1;
        end
        if (base_we) begin
          for (int i = 0; i < NUM_BASES; i++) begin
            if (b_cmd_q.base == BASE_W'(i)) begin
              base_q[i] <= sat_inc(base_cur, 1'b1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_cmd_q   <= cmd_i;
      hist_rd_q <= hist_mem[cmd_i.hist_addr];
      col_rd_q  <= col_mem[cmd_i.col_addr];
    end
    if (hist_we) begin
      hist_mem[b_cmd_q.hist_addr] <= hist_new;
      hfwd_addr_q                 <= b_cmd_q.hist_addr;
      hfwd_data_q                 <= hist_new;
    end
    if (col_we) begin
      col_mem[b_cmd_q.col_addr] <= col_new;
      cfwd_addr_q               <= b_cmd_q.col_addr;
      cfwd_data_q               <= col_new;
    end
    if (b_adv && b_is_rd) begin
      out_main_q  <= out_main_d;
      out_total_q <= out_total_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.count_main  = out_main_q;
  assign out_o.count_total = out_total_q;

endmodule

// File: hdl/fastq_read_statistics_unit.sv
// ----------------------------------------------------------------------------
// FASTQ read statistics unit
// Usage:
//   in_i carries one FASTQ file byte per transfer (op stream) or a command:
//   clear, read quality bin, read column G/C and total, read base count.
//   out_o returns one transfer per read command, in command order.
//   cfg_i writes the quality offset (reset 33); write it only while idle.
//   Throughput is one item per cycle while out_o does not stall. The front
//   decodes each item in the cycle it is taken, a four-entry command queue
//   follows, and the back reads the counter memory, then adds and writes back
//   in the next cycle, forwarding the last write so back-to-back bytes on one
//   counter chain. A read result passes the queue and the read stage and is
//   held in a result register. If out_o stalls, the back holds the pending
//   read and the queue fills; in_i.ready drops once four commands wait.
//   Reset empties the queue, sets the header line phase, column zero and
//   all counters zero at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fastq_read_statistics_unit import fqs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fqs_in_if.sink    in_i,
  fqs_out_if.source out_o,
  fqs_cfg_if.sink   cfg_i
);

  logic push, push_ready, pop, pop_valid;
  cmd_t push_cmd, pop_cmd;

  fqs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_ready_i (push_ready),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  fqs_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd)
  );

  fqs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .out_o       (out_o)
  );

endmodule

// File: hdl/fqs_checker.sv
// ----------------------------------------------------------------------------
// FASTQ statistics port checker
// Port-level checks on the result and configuration channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fqs_checker import fqs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [COUNT_W-1:0] count_main_i,
  input logic [COUNT_W-1:0] count_total_i,
  input logic               cfg_ready_i
);

  logic                 out_stall;
  logic [2*COUNT_W-1:0] out_pair;

  assign out_stall = out_valid_i && !out_ready_i;
  assign out_pair  = {count_main_i, count_total_i};

  `FQS_ASSERT(a_out_hold, out_stall |=> out_valid_i, "result dropped")
  `FQS_ASSERT(a_out_stable, out_stall |=> $stable(out_pair), "stalled result changed")
  `FQS_ASSERT(a_cfg_ready, cfg_ready_i, "offset write refused")
  `FQS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_i, "result during reset")

endmodule

bind fastq_read_statistics_unit fqs_checker u_fqs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .count_main_i  (out_o.count_main),
  .count_total_i (out_o.count_total),
  .cfg_ready_i   (cfg_i.ready)
);
